/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/ftsl_pkg.sv */
// ----------------------------------------------------------------------------
// ftsl_pkg
// Types and codes shared by the frame to segment lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsl_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PATH_HINT = 2'd0,
    PATH_HASH = 2'd1,
    PATH_SCAN = 2'd2,
    PATH_MISS = 2'd3
  } path_e;

  typedef enum logic [1:0] {
    TS_HINT,
    TS_SLOT,
    TS_IDX
  } tbl_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_HINT_CHK,
    ST_DIV,
    ST_SLOT_RD,
    ST_SLOT_TBL,
    ST_SLOT_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CLEAR,
    ST_SEG_RD,
    ST_SEG_CHK,
    ST_BDIV,
    ST_FILL_RD,
    ST_FILL_UPD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  entry_index;
    logic [31:0] seg_base;
    logic [31:0] seg_end;
    logic [31:0] seg_first_page;
    logic        seg_valid;
    logic [31:0] frame_number;
  } in_t;

  typedef struct packed {
    logic        found;
    path_e       hit_path;
    logic [3:0]  segment_index;
    logic [31:0] page_index;
  } out_t;

  typedef struct packed {
    logic     accept;
    logic     tbl_we;
    logic     span_load;
    logic     slot_clr;
    logic     hash_clr;
    logic     idx_clr;
    logic     idx_inc;
    logic     tbl_rd;
    tbl_sel_e tbl_sel;
    logic     hash_rd;
    logic     div_start;
    logic     seg_start;
    logic     slot_from_div;
    logic     fill_upd;
    logic     load_hit;
    logic     load_miss;
    path_e    path;
    logic     push;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic hint_used;
    logic tbl_hold;
    logic built;
    logic slot_used;
    logic div_done;
    logic idx_last;
    logic slot_last;
    logic rd_present;
    logic fill_more;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/ftsl_div.sv */
// ----------------------------------------------------------------------------
// ftsl_div
// Restoring divider, one quotient bit per cycle, 32-bit operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsl_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic [32:0] trial;

  assign trial      = {rem_q, quo_q[31]} - {1'b0, dvs_q};
  assign done_o     = busy_q && (cnt_q == 6'd0);
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 32'd0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q && (cnt_q != 6'd0)) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/ftsl_datapath.sv */
// ----------------------------------------------------------------------------
// ftsl_datapath
// Segment table, hash slot memory, hint, divider and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsl_datapath #(
  parameter int MAX_SEGMENTS = 16,
  parameter int HASH_SLOTS   = 512,
  parameter int HASH_SHIFT   = 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic [31:0]     cfg_data_i,
  input  wire ftsl_pkg::in_t   in_data_i,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output ftsl_pkg::out_t       out_data_o,
  input  wire ftsl_pkg::cmd_t  cmd_i,
  output ftsl_pkg::sts_t       sts_o
);

  localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SLOT_W = $clog2(HASH_SLOTS);

  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] entry;
    logic [31:0]      base;
  } slot_t;

  logic [31:0]           phys_max_q;
  ftsl_pkg::in_t         item_q;
  logic [31:0]           base_mem [MAX_SEGMENTS];
  logic [31:0]           end_mem  [MAX_SEGMENTS];
  logic [31:0]           page_mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] pres_q;
  slot_t                 hash_mem [HASH_SLOTS];
  slot_t                 hash_rd_q;
  logic [31:0]           span_q;
  logic                  built_q;
  logic                  hint_used_q;
  logic [IDX_W-1:0]      hint_q;
  logic [IDX_W-1:0]      idx_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     visits_q;
  logic [32:0]           cur_q;
  logic [31:0]           seg_base_q;
  logic [31:0]           seg_end_q;
  logic [IDX_W-1:0]      tbl_raddr;
  logic [31:0]           rd_base_q;
  logic [31:0]           rd_end_q;
  logic [31:0]           rd_page_q;
  logic                  rd_pres_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [32:0]           span_full;
  logic [31:0]           span_d;
  logic [32:0]           cur_next;
  logic                  wr_ok;
  logic                  replace;
  logic [31:0]           frame;
  logic                  div_done;
  logic [31:0]           quotient;
  ftsl_pkg::out_t        pend_q;
  ftsl_pkg::out_t        out_q;
  logic                  out_valid_q;
  logic                  out_free;

  assign frame     = item_q.frame_number;
  assign span_full = ({1'b0, phys_max_q} + 33'd1) >> HASH_SHIFT;
  assign span_d    = (span_full == 33'd0) ? 32'd1 : span_full[31:0];
  assign cur_next  = cur_q + {1'b0, span_q};
  assign wr_ok     = 32'(item_q.entry_index) < 32'(MAX_SEGMENTS);
  assign replace   = !hash_rd_q.used || (hash_rd_q.base > seg_base_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.tbl_sel)
      ftsl_pkg::TS_HINT: tbl_raddr = hint_q;
      ftsl_pkg::TS_SLOT: tbl_raddr = hash_rd_q.entry;
      default:           tbl_raddr = idx_q;
    endcase
  end

  ftsl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start || cmd_i.seg_start),
    .dividend_i (cmd_i.seg_start ? rd_base_q : frame),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_max_q  <= 32'd0;
      span_q      <= 32'd1;
      built_q     <= 1'b0;
      hint_used_q <= 1'b0;
      hint_q      <= '0;
      pres_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        phys_max_q <= cfg_data_i;
      end
      if (cmd_i.span_load) begin
        span_q  <= span_d;
        built_q <= 1'b1;
      end
      if (cmd_i.tbl_we && wr_ok) begin
        pres_q[IDX_W'(item_q.entry_index)] <= item_q.seg_valid;
      end
      if (cmd_i.load_hit) begin
        hint_used_q <= 1'b1;
        hint_q      <= rd_idx_q;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.tbl_we && wr_ok) begin
      base_mem[IDX_W'(item_q.entry_index)] <= item_q.seg_base;
      end_mem[IDX_W'(item_q.entry_index)]  <= item_q.seg_end;
      page_mem[IDX_W'(item_q.entry_index)] <= item_q.seg_first_page;
    end
    if (cmd_i.tbl_rd) begin
      rd_base_q <= base_mem[tbl_raddr];
      rd_end_q  <= end_mem[tbl_raddr];
      rd_page_q <= page_mem[tbl_raddr];
      rd_pres_q <= pres_q[tbl_raddr];
      rd_idx_q  <= tbl_raddr;
    end
    if (cmd_i.hash_clr) begin
      hash_mem[slot_q] <= '0;
    end else if (cmd_i.fill_upd && replace) begin
      hash_mem[slot_q] <= '{used: 1'b1, entry: idx_q, base: seg_base_q};
    end
    if (cmd_i.hash_rd) begin
      hash_rd_q <= hash_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_clr) begin
      slot_q <= '0;
    end else if (cmd_i.slot_from_div) begin
      slot_q <= quotient[SLOT_W-1:0];
    end else if (cmd_i.hash_clr || cmd_i.fill_upd) begin
      slot_q <= slot_q + SLOT_W'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.seg_start) begin
      seg_base_q <= rd_base_q;
      seg_end_q  <= rd_end_q;
      cur_q      <= {1'b0, rd_base_q};
      visits_q   <= '0;
    end else if (cmd_i.fill_upd) begin
      cur_q    <= cur_next;
      visits_q <= visits_q + SLOT_W'(1);
    end
    if (cmd_i.load_hit) begin
      pend_q.found         <= 1'b1;
      pend_q.hit_path      <= cmd_i.path;
      pend_q.segment_index <= 4'(rd_idx_q);
      pend_q.page_index    <= rd_page_q + (frame - rd_base_q);
    end else if (cmd_i.load_miss) begin
      pend_q.found         <= 1'b0;
      pend_q.hit_path      <= ftsl_pkg::PATH_MISS;
      pend_q.segment_index <= 4'd0;
      pend_q.page_index    <= 32'd0;
    end
    if (cmd_i.push) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.op         = item_q.op;
    sts_o.hint_used  = hint_used_q;
    sts_o.tbl_hold   = rd_pres_q && (frame >= rd_base_q) && (frame < rd_end_q);
    sts_o.built      = built_q;
    sts_o.slot_used  = built_q && hash_rd_q.used;
    sts_o.div_done   = div_done;
    sts_o.idx_last   = idx_q == IDX_W'(MAX_SEGMENTS - 1);
    sts_o.slot_last  = slot_q == SLOT_W'(HASH_SLOTS - 1);
    sts_o.rd_present = rd_pres_q;
    sts_o.fill_more  = (cur_next < {1'b0, seg_end_q}) &&
                       (visits_q != SLOT_W'(HASH_SLOTS - 1));
    sts_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

/* hdl/ftsl_ctrl.sv */
// ----------------------------------------------------------------------------
// ftsl_ctrl
// Sequencer for entry write, hash build and lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsl_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ftsl_pkg::sts_t  sts_i,
  output ftsl_pkg::cmd_t       cmd_o
);

  ftsl_pkg::state_e state_q;
  ftsl_pkg::state_e state_d;

  assign in_ready_o = (state_q == ftsl_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftsl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftsl_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ftsl_pkg::ST_DISPATCH;
      end
      ftsl_pkg::ST_DISPATCH: begin
        unique case (sts_i.op)
          ftsl_pkg::OP_BUILD:  state_d = ftsl_pkg::ST_CLEAR;
          ftsl_pkg::OP_LOOKUP: state_d = ftsl_pkg::ST_HINT_CHK;
          default:             state_d = ftsl_pkg::ST_FINISH;
        endcase
      end
      ftsl_pkg::ST_HINT_CHK: begin
        if (sts_i.hint_used && sts_i.tbl_hold) state_d = ftsl_pkg::ST_FINISH;
        else if (sts_i.built)                  state_d = ftsl_pkg::ST_DIV;
        else                                   state_d = ftsl_pkg::ST_SCAN_RD;
      end
      ftsl_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = ftsl_pkg::ST_SLOT_RD;
      end
      ftsl_pkg::ST_SLOT_RD: state_d = ftsl_pkg::ST_SLOT_TBL;
      ftsl_pkg::ST_SLOT_TBL: begin
        state_d = sts_i.slot_used ? ftsl_pkg::ST_SLOT_CHK : ftsl_pkg::ST_SCAN_RD;
      end
      ftsl_pkg::ST_SLOT_CHK: begin
        state_d = sts_i.tbl_hold ? ftsl_pkg::ST_FINISH : ftsl_pkg::ST_SCAN_RD;
      end
      ftsl_pkg::ST_SCAN_RD: state_d = ftsl_pkg::ST_SCAN_CHK;
      ftsl_pkg::ST_SCAN_CHK: begin
        if (sts_i.tbl_hold || sts_i.idx_last) state_d = ftsl_pkg::ST_FINISH;
        else                                  state_d = ftsl_pkg::ST_SCAN_RD;
      end
      ftsl_pkg::ST_CLEAR: begin
        if (sts_i.slot_last) state_d = ftsl_pkg::ST_SEG_RD;
      end
      ftsl_pkg::ST_SEG_RD: state_d = ftsl_pkg::ST_SEG_CHK;
      ftsl_pkg::ST_SEG_CHK: begin
        if (sts_i.rd_present)    state_d = ftsl_pkg::ST_BDIV;
        else if (sts_i.idx_last) state_d = ftsl_pkg::ST_FINISH;
        else                     state_d = ftsl_pkg::ST_SEG_RD;
      end
      ftsl_pkg::ST_BDIV: begin
        if (sts_i.div_done) state_d = ftsl_pkg::ST_FILL_RD;
      end
      ftsl_pkg::ST_FILL_RD: state_d = ftsl_pkg::ST_FILL_UPD;
      ftsl_pkg::ST_FILL_UPD: begin
        if (sts_i.fill_more)     state_d = ftsl_pkg::ST_FILL_RD;
        else if (sts_i.idx_last) state_d = ftsl_pkg::ST_FINISH;
        else                     state_d = ftsl_pkg::ST_SEG_RD;
      end
      ftsl_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = ftsl_pkg::ST_IDLE;
      end
      default: state_d = ftsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ftsl_pkg::ST_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      ftsl_pkg::ST_DISPATCH: begin
        unique case (sts_i.op)
          ftsl_pkg::OP_WRITE: begin
            cmd_o.tbl_we    = 1'b1;
            cmd_o.load_miss = 1'b1;
          end
          ftsl_pkg::OP_BUILD: begin
            cmd_o.span_load = 1'b1;
            cmd_o.slot_clr  = 1'b1;
          end
          ftsl_pkg::OP_LOOKUP: begin
            cmd_o.tbl_rd  = 1'b1;
            cmd_o.tbl_sel = ftsl_pkg::TS_HINT;
          end
          default: begin
            cmd_o.load_miss = 1'b1;
          end
        endcase
      end
      ftsl_pkg::ST_HINT_CHK: begin
        if (sts_i.hint_used && sts_i.tbl_hold) begin
          cmd_o.load_hit = 1'b1;
          cmd_o.path     = ftsl_pkg::PATH_HINT;
        end else if (sts_i.built) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.idx_clr = 1'b1;
        end
      end
      ftsl_pkg::ST_DIV, ftsl_pkg::ST_BDIV: begin
        cmd_o.slot_from_div = sts_i.div_done;
      end
      ftsl_pkg::ST_SLOT_RD, ftsl_pkg::ST_FILL_RD: begin
        cmd_o.hash_rd = 1'b1;
      end
      ftsl_pkg::ST_SLOT_TBL: begin
        if (sts_i.slot_used) begin
          cmd_o.tbl_rd  = 1'b1;
          cmd_o.tbl_sel = ftsl_pkg::TS_SLOT;
        end else begin
          cmd_o.idx_clr = 1'b1;
        end
      end
      ftsl_pkg::ST_SLOT_CHK: begin
        if (sts_i.tbl_hold) begin
          cmd_o.load_hit = 1'b1;
          cmd_o.path     = ftsl_pkg::PATH_HASH;
        end else begin
          cmd_o.idx_clr = 1'b1;
        end
      end
      ftsl_pkg::ST_SCAN_RD, ftsl_pkg::ST_SEG_RD: begin
        cmd_o.tbl_rd  = 1'b1;
        cmd_o.tbl_sel = ftsl_pkg::TS_IDX;
      end
      ftsl_pkg::ST_SCAN_CHK: begin
        if (sts_i.tbl_hold) begin
          cmd_o.load_hit = 1'b1;
          cmd_o.path     = ftsl_pkg::PATH_SCAN;
        end else if (sts_i.idx_last) begin
          cmd_o.load_miss = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ftsl_pkg::ST_CLEAR: begin
        cmd_o.hash_clr = 1'b1;
        cmd_o.idx_clr  = sts_i.slot_last;
      end
      ftsl_pkg::ST_SEG_CHK: begin
        if (sts_i.rd_present) begin
          cmd_o.seg_start = 1'b1;
        end else if (sts_i.idx_last) begin
          cmd_o.load_miss = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ftsl_pkg::ST_FILL_UPD: begin
        cmd_o.fill_upd = 1'b1;
        if (!sts_i.fill_more) begin
          if (sts_i.idx_last) cmd_o.load_miss = 1'b1;
          else                cmd_o.idx_inc   = 1'b1;
        end
      end
      ftsl_pkg::ST_FINISH: begin
        cmd_o.push = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/frame_to_segment_lookup_unit.sv */
// ----------------------------------------------------------------------------
// frame_to_segment_lookup_unit
// Maps a physical frame number to its segment and global page index.
// ----------------------------------------------------------------------------
// Input channel carries one op per transfer: entry write, hash build, lookup, no-op.
// Each transfer gives exactly one result transfer; non-lookups answer as miss.
// One item in flight; the next is taken once the result sits in the output
// register, so a stalled receiver holds only the block's second result.
// Steps per item, from transfer to result valid:
//   write or no-op      table write (write only), then the miss result
//   lookup, hint hit    the entry of the last hit is checked first
//   lookup, hash hit    the serial divider gives the slot, whose entry is checked
//   lookup, scan        table entries are checked in order from the first
//   build               every hash slot is cleared, then for each present
//                       entry the slots that it covers are filled
// Reset clears the table present bits, hint, span (one) and phys_max; the
// hash memory counts as empty until the first build clears it. phys_max is
// written via the config channel; the user must do so only while idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module frame_to_segment_lookup_unit #(
  parameter int MAX_SEGMENTS = 16,
  parameter int HASH_SLOTS   = 512,
  parameter int HASH_SHIFT   = 9
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [31:0]    cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ftsl_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ftsl_pkg::out_t      out_data_o
);

  ftsl_pkg::cmd_t cmd;
  ftsl_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ftsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftsl_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .HASH_SLOTS   (HASH_SLOTS),
    .HASH_SHIFT   (HASH_SHIFT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `ASSERT_RST(a_found_path, !out_valid_o || (out_data_o.found == (out_data_o.hit_path != ftsl_pkg::PATH_MISS)), "found and hit path disagree")
  `ASSERT_RST(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item taken while busy")
  `ASSERT_RST(a_idx_range, (out_valid_o && out_data_o.found) |-> (32'(out_data_o.segment_index) < 32'(MAX_SEGMENTS)), "segment index beyond table")

endmodule

`default_nettype wire
